// File: sv/first_fit_pool_allocator_assert.svh
// Assertion macros for the first-fit pool allocator.
// Used by the datapath; expects clk and rst in scope.
`ifndef FIRST_FIT_POOL_ALLOCATOR_ASSERT_SVH
`define FIRST_FIT_POOL_ALLOCATOR_ASSERT_SVH

// same-cycle implication
`define FFPA_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("ffpa assertion failed");

// next-cycle implication
`define FFPA_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("ffpa assertion failed");

`endif

// File: sv/ffpa_pkg.sv
// Shared types and constants for the first-fit pool allocator.
// No dependencies.
package ffpa_pkg;

  localparam int ARENA_GRANULES = 4096;
  localparam int GRAN_W         = $clog2(ARENA_GRANULES);
  localparam int NEED_W         = GRAN_W + 1;
  localparam int BYTES_W        = 16;
  localparam int MARGIN_W       = 4;
  localparam logic [MARGIN_W-1:0] MARGIN_RESET = 4'd2;

  typedef logic [GRAN_W-1:0] gran_t;

  typedef struct packed {
    logic  valid;
    gran_t idx;
  } link_t;

  typedef enum logic [3:0] {
    ST_INIT,
    ST_IDLE,
    ST_FREE,
    ST_CHECK,
    ST_WR_REM,
    ST_WR_PREV,
    ST_WR_CUR,
    ST_RESP
  } state_t;

  typedef struct packed {
    logic init;
    logic load_req;
    logic follow;
    logic hit;
    logic fail;
    logic wr_rem;
    logic wr_prev;
    logic wr_cur;
    logic do_free;
    logic load_out;
  } ctl_cmd_t;

  typedef struct packed {
    logic head_valid;
    logic is_free;
    logic free_null;
    logic fit;
    logic can_follow;
    logic out_busy;
  } dp_stat_t;

endpackage

// File: sv/ffpa_ctrl.sv
// Sequencer for the allocator: request intake, list walk, header updates.
// Depends on ffpa_pkg.
module ffpa_ctrl
  import ffpa_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  output logic     in_ready,
  input  dp_stat_t stat,
  output ctl_cmd_t cmd
);

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_INIT;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_INIT: state_next = ST_IDLE;
      ST_IDLE: begin
        if (in_valid) begin
          if (stat.is_free) begin
            state_next = stat.free_null ? ST_RESP : ST_FREE;
          end else begin
            state_next = stat.head_valid ? ST_CHECK : ST_RESP;
          end
        end
      end
      ST_FREE: state_next = ST_RESP;
      ST_CHECK: begin
        if (stat.fit) begin
          state_next = ST_WR_REM;
        end else if (!stat.can_follow) begin
          state_next = ST_RESP;
        end
      end
      ST_WR_REM:  state_next = ST_WR_PREV;
      ST_WR_PREV: state_next = ST_WR_CUR;
      ST_WR_CUR:  state_next = ST_RESP;
      ST_RESP: begin
        if (!stat.out_busy) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_INIT;
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    case (state)
      ST_INIT: cmd.init = 1'b1;
      ST_IDLE: begin
        in_ready     = 1'b1;
        cmd.load_req = in_valid;
        cmd.fail     = in_valid && !stat.is_free && !stat.head_valid;
      end
      ST_FREE: cmd.do_free = 1'b1;
      ST_CHECK: begin
        cmd.hit    = stat.fit;
        cmd.follow = !stat.fit && stat.can_follow;
        cmd.fail   = !stat.fit && !stat.can_follow;
      end
      ST_WR_REM:  cmd.wr_rem  = 1'b1;
      ST_WR_PREV: cmd.wr_prev = 1'b1;
      ST_WR_CUR:  cmd.wr_cur  = 1'b1;
      ST_RESP:    cmd.load_out = !stat.out_busy;
      default: cmd = '0;
    endcase
  end

endmodule

// File: sv/ffpa_datapath.sv
// Header stores, walk registers, list head, split margin and output word.
// Depends on ffpa_pkg and first_fit_pool_allocator_assert.svh.
`include "first_fit_pool_allocator_assert.svh"

module ffpa_datapath
  import ffpa_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  ctl_cmd_t            cmd,
  output dp_stat_t            stat,
  input  logic                cfg_valid,
  input  logic [MARGIN_W-1:0] cfg_data,
  input  logic                req_type,
  input  logic [BYTES_W-1:0]  req_bytes,
  input  logic [BYTES_W-1:0]  free_offset,
  output logic                out_valid,
  input  logic                out_ready,
  output logic                status,
  output logic [BYTES_W-1:0]  payload_offset
);

  localparam gran_t LAST_STEP = GRAN_W'(ARENA_GRANULES - 1);

  gran_t               size_mem [ARENA_GRANULES];
  link_t               link_mem [ARENA_GRANULES];

  logic [MARGIN_W-1:0] split_margin;
  gran_t               head;
  logic                head_valid;
  logic [NEED_W-1:0]   need;
  gran_t               cur;
  gran_t               prev;
  logic                have_prev;
  gran_t               steps;
  gran_t               sz;
  link_t               nlink;
  logic                split;
  gran_t               rem;
  logic                res_fail;
  logic [BYTES_W-1:0]  res_off;
  gran_t               rd_size;
  link_t               rd_link;

  gran_t               rd_addr;
  logic                size_we;
  gran_t               size_waddr;
  gran_t               size_wdata;
  logic                link_we;
  gran_t               link_waddr;
  link_t               link_wdata;

  logic [BYTES_W:0]    bytes_sum;
  logic [NEED_W-1:0]   need_raw;
  logic [NEED_W-1:0]   need_next;
  gran_t               free_gran;
  logic [NEED_W+1:0]   split_lim;
  logic [NEED_W+1:0]   rem_full;
  logic                split_next;
  gran_t               cur_inc;

  assign bytes_sum = {1'b0, req_bytes} + (BYTES_W+1)'(15);
  assign need_raw  = bytes_sum[BYTES_W:4];
  assign need_next = (need_raw == '0) ? NEED_W'(1) : need_raw;
  assign free_gran = free_offset[BYTES_W-1:4];

  assign split_lim  = (NEED_W+2)'(need) + (NEED_W+2)'(1) + (NEED_W+2)'(split_margin);
  assign rem_full   = (NEED_W+2)'(cur) + (NEED_W+2)'(1) + (NEED_W+2)'(need);
  assign split_next = ((NEED_W+2)'(rd_size) >= split_lim)
                      && (rem_full < (NEED_W+2)'(ARENA_GRANULES));
  assign cur_inc    = cur + 1'b1;

  assign stat.head_valid = head_valid;
  assign stat.is_free    = req_type;
  assign stat.free_null  = (free_gran == '0);
  assign stat.fit        = (NEED_W'(rd_size) >= need);
  assign stat.can_follow = rd_link.valid && (steps != LAST_STEP);
  assign stat.out_busy   = out_valid && !out_ready;

  assign rd_addr = cmd.follow ? rd_link.idx : head;

  always_comb begin
    size_we    = 1'b0;
    size_waddr = cur;
    size_wdata = GRAN_W'(need);
    link_we    = 1'b0;
    link_waddr = cur;
    link_wdata = '0;
    if (cmd.init) begin
      size_we    = 1'b1;
      size_waddr = '0;
      size_wdata = LAST_STEP;
      link_we    = 1'b1;
      link_waddr = '0;
    end else if (cmd.do_free) begin
      link_we    = 1'b1;
      link_wdata = '{valid: head_valid, idx: head};
    end else if (cmd.wr_rem) begin
      size_we    = split;
      size_waddr = rem;
      size_wdata = sz - GRAN_W'(need) - 1'b1;
      link_we    = split;
      link_waddr = rem;
      link_wdata = nlink;
    end else if (cmd.wr_prev) begin
      size_we    = split;
      link_we    = have_prev;
      link_waddr = prev;
      link_wdata = split ? link_t'{valid: 1'b1, idx: rem} : nlink;
    end else if (cmd.wr_cur) begin
      link_we    = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (size_we) begin
      size_mem[size_waddr] <= size_wdata;
    end
    if (link_we) begin
      link_mem[link_waddr] <= link_wdata;
    end
    rd_size <= size_mem[rd_addr];
    rd_link <= link_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      split_margin <= MARGIN_RESET;
      head         <= '0;
      head_valid   <= 1'b1;
      out_valid    <= 1'b0;
    end else begin
      if (cfg_valid) begin
        split_margin <= cfg_data;
      end
      if (cmd.do_free) begin
        head       <= cur;
        head_valid <= 1'b1;
      end else if (cmd.wr_prev && !have_prev) begin
        head       <= split ? rem : nlink.idx;
        head_valid <= split ? 1'b1 : nlink.valid;
      end
      if (cmd.load_out) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_req) begin
      need      <= need_next;
      cur       <= req_type ? (free_gran - 1'b1) : head;
      have_prev <= 1'b0;
      steps     <= '0;
      res_fail  <= cmd.fail;
      res_off   <= '0;
    end else if (cmd.fail) begin
      res_fail <= 1'b1;
      res_off  <= '0;
    end
    if (cmd.follow) begin
      prev      <= cur;
      have_prev <= 1'b1;
      cur       <= rd_link.idx;
      steps     <= steps + 1'b1;
    end
    if (cmd.hit) begin
      sz    <= rd_size;
      nlink <= rd_link;
      split <= split_next;
      rem   <= GRAN_W'(rem_full);
    end
    if (cmd.wr_cur) begin
      res_off <= BYTES_W'({cur_inc, 4'b0000});
    end
    if (cmd.load_out) begin
      status         <= res_fail;
      payload_offset <= res_off;
    end
  end

  `FFPA_ASSERT_IMP(a_no_overwrite, cmd.load_out, !out_valid || out_ready)
  `FFPA_ASSERT_IMP(a_rem_past_cur, cmd.wr_rem && split, rem > cur)
  `FFPA_ASSERT_NXT(a_free_sets_head, cmd.do_free, head_valid && head == $past(cur))

endmodule

// File: sv/first_fit_pool_allocator.sv
// First-fit free-list allocator over a 16-byte-granule arena.
// Top level: joins ffpa_ctrl and ffpa_datapath; depends on ffpa_pkg.
//
// Usage:
//   Input channel in_valid/in_ready carries one word: req_type (0 allocate,
//   1 free), req_bytes and free_offset. Output channel out_valid/out_ready
//   returns one word per request: status (1 = no fit) and payload_offset.
//   Config channel cfg_valid/cfg_ready writes split_margin; cfg_ready is
//   always high, write only while the block is idle.
// Sequence (from the accepting edge until out_valid rises):
//   free: FREE, then RESP (straight to RESP for a null offset).
//   allocate: CHECK once per free-list node visited (one header read
//   per cycle from the size/link memories, at most 4096), then WR_REM,
//   WR_PREV, WR_CUR, RESP; a no-fit answer goes straight to RESP. The next
//   request is taken at the edge after the result is loaded, never sooner.
// Reset: synchronous rst; the INIT state after release writes the arena header
//   (granule 0, size 4095, no link), then in_ready rises.
// Stall: a held result sits in the output register; the walk finishes and
//   the block waits with in_ready low until the output word is taken.
module first_fit_pool_allocator
  import ffpa_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [MARGIN_W-1:0] cfg_data,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic                req_type,
  input  logic [BYTES_W-1:0]  req_bytes,
  input  logic [BYTES_W-1:0]  free_offset,
  output logic                out_valid,
  input  logic                out_ready,
  output logic                status,
  output logic [BYTES_W-1:0]  payload_offset
);

  ctl_cmd_t cmd;
  dp_stat_t stat;

  assign cfg_ready = 1'b1;

  ffpa_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  ffpa_datapath u_dp (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .stat           (stat),
    .cfg_valid      (cfg_valid),
    .cfg_data       (cfg_data),
    .req_type       (req_type),
    .req_bytes      (req_bytes),
    .free_offset    (free_offset),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .status         (status),
    .payload_offset (payload_offset)
  );

endmodule

// File: tb/alloc_check_pkg.sv
// Request/status codes and the scoreboard for the first-fit pool allocator bench.
// The scoreboard tracks its own copy of the arena headers, free list and margin.
// Depends on ffpa_pkg.
package alloc_check_pkg;
  import ffpa_pkg::*;

  typedef enum logic {
    REQ_ALLOC = 1'b0,
    REQ_FREE  = 1'b1
  } req_kind_e;

  typedef enum logic {
    ALLOC_DONE   = 1'b0,
    ALLOC_NO_FIT = 1'b1
  } alloc_status_e;

  typedef struct packed {
    alloc_status_e        status;
    logic [BYTES_W-1:0]   offset;
  } alloc_word_t;

  class alloc_scoreboard;
    gran_t         size_mem [ARENA_GRANULES];
    link_t         link_mem [ARENA_GRANULES];
    link_t         head;
    int unsigned   margin;
    alloc_word_t   owed_words [$];
    int unsigned   mismatches;

    function new();
      foreach (size_mem[i]) begin
        size_mem[i] = '0;
        link_mem[i] = '0;
      end
      size_mem[0] = gran_t'(ARENA_GRANULES - 1);
      head.valid  = 1'b1;
      head.idx    = '0;
      margin      = 32'(MARGIN_RESET);
      mismatches  = 0;
    endfunction

    function void set_margin(logic [MARGIN_W-1:0] value);
      margin = 32'(value);
    endfunction

    function int pending();
      return owed_words.size();
    endfunction

    function int unsigned failures();
      return mismatches;
    endfunction

    // Applies one accepted request to the arena copy, queues the word it owes
    // and returns the payload offset it hands out.
    function logic [BYTES_W-1:0] note_request(req_kind_e kind, logic [BYTES_W-1:0] nbytes,
                                              logic [BYTES_W-1:0] foff);
      alloc_word_t w;
      link_t       walk;
      link_t       nxt;
      int          need;
      int          cur;
      int          prev;
      int          rem;
      int          sz;
      int          hdr;
      int          steps;
      bit          have_prev;
      bit          found;
      w.status  = ALLOC_DONE;
      w.offset  = '0;
      if (kind == REQ_FREE) begin
        hdr = int'(foff[BYTES_W-1:4]) - 1;
        if (foff[BYTES_W-1:4] != '0 && hdr < ARENA_GRANULES) begin
          link_mem[hdr] = head;
          head.valid    = 1'b1;
          head.idx      = gran_t'(hdr);
        end
      end else begin
        need = (int'(nbytes) + 15) >> 4;
        if (need == 0) need = 1;
        walk      = head;
        steps     = 0;
        have_prev = 1'b0;
        found     = 1'b0;
        prev      = 0;
        while (walk.valid && steps < ARENA_GRANULES && !found) begin
          steps++;
          cur = int'(walk.idx);
          sz  = int'(size_mem[cur]);
          if (sz >= need) begin
            nxt = link_mem[cur];
            rem = cur + 1 + need;
            if (sz >= need + 1 + int'(margin) && rem < ARENA_GRANULES) begin
              size_mem[rem] = gran_t'(sz - need - 1);
              link_mem[rem] = nxt;
              size_mem[cur] = gran_t'(need);
              nxt.valid     = 1'b1;
              nxt.idx       = gran_t'(rem);
            end
            if (have_prev) link_mem[prev] = nxt;
            else head = nxt;
            link_mem[cur].valid = 1'b0;
            w.offset = BYTES_W'((cur + 1) << 4);
            found    = 1'b1;
          end else begin
            have_prev = 1'b1;
            prev      = cur;
            walk      = link_mem[cur];
          end
        end
        if (!found) w.status = ALLOC_NO_FIT;
      end
      owed_words.push_back(w);
      return w.offset;
    endfunction

    function void check(logic status, logic [BYTES_W-1:0] offset);
      alloc_word_t w;
      if (owed_words.size() == 0) begin
        $display("%0t: unexpected word: expected none, got status=%0b offset=%04h",
                 $time, status, offset);
        mismatches++;
        return;
      end
      w = owed_words.pop_front();
      if (status !== w.status) begin
        $display("%0t: status mismatch: expected %0b, got %0b", $time, w.status, status);
        mismatches++;
      end
      if (offset !== w.offset) begin
        $display("%0t: payload_offset mismatch: expected %04h, got %04h",
                 $time, w.offset, offset);
        mismatches++;
      end
    endfunction
  endclass

endpackage

// File: tb/testbench.sv
// Top-level bench for first_fit_pool_allocator: directed and random allocate/free
// traffic with random stalls, checked word by word by alloc_scoreboard.
// Depends on ffpa_pkg, alloc_check_pkg and the allocator RTL.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import ffpa_pkg::*;
  import alloc_check_pkg::*;

  logic                clk = 1'b0;
  logic                rst;
  logic                cfg_valid;
  logic                cfg_ready;
  logic [MARGIN_W-1:0] cfg_data;
  logic                in_valid;
  logic                in_ready;
  logic                req_type;
  logic [BYTES_W-1:0]  req_bytes;
  logic [BYTES_W-1:0]  free_offset;
  logic                out_valid;
  logic                out_ready;
  logic                status;
  logic [BYTES_W-1:0]  payload_offset;

  alloc_scoreboard     sb = new();
  bit                  no_idle = 1'b0;
  logic [BYTES_W-1:0]  live_offs [$];

  first_fit_pool_allocator u_top (
    .clk            (clk),
    .rst            (rst),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_data       (cfg_data),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .req_type       (req_type),
    .req_bytes      (req_bytes),
    .free_offset    (free_offset),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .status         (status),
    .payload_offset (payload_offset)
  );

  always #10 clk = ~clk;

  function automatic int live_slot(logic [BYTES_W-1:0] key);
    for (int i = 0; i < live_offs.size(); i++) begin
      if (live_offs[i] == key) return i;
    end
    return -1;
  endfunction

  task automatic send(input req_kind_e kind, input logic [BYTES_W-1:0] nbytes,
                      input logic [BYTES_W-1:0] foff, output logic [BYTES_W-1:0] got);
    int slot;
    if (!no_idle && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 19)) @(posedge clk);
    end
    in_valid    <= 1'b1;
    req_type    <= kind;
    req_bytes   <= nbytes;
    free_offset <= foff;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    got = sb.note_request(kind, nbytes, foff);
    if (kind == REQ_FREE) begin
      slot = live_slot({foff[BYTES_W-1:4], 4'h0});
      if (slot >= 0) live_offs.delete(slot);
    end else if (got != '0 && live_slot(got) < 0) begin
      live_offs.push_back(got);
    end
  endtask

  task automatic send_random();
    logic [BYTES_W-1:0] nbytes;
    logic [BYTES_W-1:0] foff;
    logic [BYTES_W-1:0] got;
    int                 sel;
    nbytes = 16'($urandom);
    foff   = 16'($urandom);
    if ($urandom_range(0, 99) < 45 && live_offs.size() > 0) begin
      if ($urandom_range(0, 7) == 0) begin
        foff = 16'($urandom_range(0, 15));
      end else begin
        sel  = $urandom_range(0, live_offs.size() - 1);
        foff = live_offs[sel] | 16'($urandom_range(0, 15));
      end
      send(REQ_FREE, nbytes, foff, got);
    end else begin
      sel = $urandom_range(0, 99);
      if (sel < 85) nbytes = 16'($urandom_range(0, 255));
      else if (sel < 97) nbytes = 16'($urandom_range(256, 4096));
      send(REQ_ALLOC, nbytes, foff, got);
    end
  endtask

  task automatic write_margin(input logic [MARGIN_W-1:0] value);
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    sb.set_margin(value);
  endtask

  task automatic run_directed();
    logic [BYTES_W-1:0] a;
    logic [BYTES_W-1:0] d;
    logic [BYTES_W-1:0] scratch;
    send(REQ_ALLOC, 16'd0, 16'($urandom), a);          // zero bytes still takes a granule
    send(REQ_ALLOC, 16'hFFFF, 16'($urandom), scratch); // bigger than the arena
    send(REQ_ALLOC, 16'd1, 16'($urandom), scratch);
    send(REQ_FREE, 16'($urandom), a | 16'h000F, scratch);
    send(REQ_FREE, 16'($urandom), 16'd5, scratch);     // null offsets
    send(REQ_FREE, 16'($urandom), 16'd0, scratch);
    send(REQ_ALLOC, 16'd16, 16'($urandom), scratch);   // too small to split
    send(REQ_ALLOC, 16'd32768, 16'($urandom), scratch);
    send(REQ_ALLOC, 16'd32000, 16'($urandom), d);      // lands above 32 KiB
    send(REQ_FREE, 16'($urandom), d | 16'h000A, scratch);
    send(REQ_ALLOC, 16'd31985, 16'($urandom), d);      // exact fit, taken whole
    send(REQ_FREE, 16'($urandom), d, scratch);
    send(REQ_FREE, 16'($urandom), d, scratch);         // double free closes a loop
    send(REQ_ALLOC, 16'd65520, 16'($urandom), scratch); // walk gives up on the loop
    send(REQ_ALLOC, 16'd31985, 16'($urandom), scratch);
    send(REQ_ALLOC, 16'd31985, 16'($urandom), scratch); // handed out twice, list drains
    send(REQ_ALLOC, 16'd0, 16'($urandom), scratch);     // empty list
    send(REQ_FREE, 16'($urandom), d, scratch);
    send(REQ_ALLOC, 16'd4000, 16'($urandom), scratch);
  endtask

  initial begin : stimulus
    logic [MARGIN_W-1:0] m;
    rst         <= 1'b1;
    cfg_valid   <= 1'b0;
    cfg_data    <= '0;
    in_valid    <= 1'b0;
    req_type    <= REQ_ALLOC;
    req_bytes   <= '0;
    free_offset <= '0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    run_directed();
    for (int p = 0; p < 4; p++) begin
      case (p)
        0: m = '0;
        1: m = '1;
        2: m = 4'($urandom_range(1, 14));
        default: m = 4'($urandom_range(0, 15));
      endcase
      write_margin(m);
      if (p == 3) no_idle = 1'b1;
      repeat (175) send_random();
    end
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (16) @(posedge clk);
    if (sb.failures() == 0) begin
      $display("** first_fit_pool_allocator: PASSED **");
    end else begin
      $display("** first_fit_pool_allocator: FAILED **");
    end
    $finish;
  end

  initial begin : result_sink
    int taken = 0;
    bit held  = 1'b0;
    out_ready <= 1'b0;
    @(posedge clk);
    forever begin
      if (taken == 40 && !held) begin
        // long hold-off so the block backs up and stalls its input
        held = 1'b1;
        out_ready <= 1'b0;
        repeat (500) @(posedge clk);
      end else if (!no_idle && $urandom_range(0, 4) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 19)) @(posedge clk);
      end
      out_ready <= 1'b1;
      @(posedge clk);
      if (out_valid) begin
        sb.check(status, payload_offset);
        taken++;
      end
    end
  end

  initial begin : watchdog
    #(200_000_000);
    $display("** first_fit_pool_allocator: FAILED **");
    $finish;
  end

endmodule

// File: first_fit_pool_allocator.f
+incdir+sv
sv/ffpa_pkg.sv
sv/ffpa_ctrl.sv
sv/ffpa_datapath.sv
sv/first_fit_pool_allocator.sv
tb/alloc_check_pkg.sv
tb/testbench.sv
